FILE: design/lkvc_pkg.sv
package lkvc_pkg;

  localparam int KEY_W        = 16;
  localparam int VAL_W        = 32;
  localparam int CAP_W        = 5;
  localparam int ENTRIES_DFLT = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // mode codes (s_axis_tuser)
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // per-cycle controls broadcast to every cell
  typedef struct packed {
    logic capture;  // latch compare result against the incoming key
    logic update;   // apply recency shift
    logic hit_any;  // some cell matched
    logic is_set;
    logic clip;     // capacity written: drop entries past new capacity
  } cell_ctl_t;

endpackage

FILE: design/lkvc_cell.sv
module lkvc_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  lkvc_pkg::cell_ctl_t          ctl,
  input  logic [lkvc_pkg::KEY_W-1:0]   cmp_key,
  input  logic                         below_cap,
  input  logic                         below_new_cap,
  input  lkvc_pkg::entry_t             prev,
  input  logic                         seen_in,
  output lkvc_pkg::entry_t             cur,
  output logic                         match,
  output logic                         seen_out,
  output logic [lkvc_pkg::VAL_W-1:0]   match_value
);

  logic                       valid;
  logic [lkvc_pkg::KEY_W-1:0] key;
  logic [lkvc_pkg::VAL_W-1:0] value;
  logic                       shift;

  // hit: everything up to and including the matching cell moves back one
  // set miss: fill or push back up to the first free cell, bounded by capacity
  assign shift = ctl.hit_any ? !seen_in : (ctl.is_set && below_cap && prev.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.capture) begin
        match <= valid && (key == cmp_key);
      end
      if (ctl.update && shift) begin
        valid <= prev.valid;
      end else if (ctl.clip) begin
        valid <= valid && below_new_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.update && shift) begin
      key   <= prev.key;
      value <= prev.value;
    end
  end

  assign cur.valid   = valid;
  assign cur.key     = key;
  assign cur.value   = value;
  assign seen_out    = seen_in | match;
  assign match_value = match ? value : '0;

endmodule

FILE: design/lru_key_value_cache.sv
// LRU key/value cache: a fully associative store of up to ENTRIES key/value
// pairs held in a row of cells in recency order, cell 0 being the most recent.
// Each input transfer carries mode (tuser: 0 get, 1 set), key and write_value;
// each produces exactly one result transfer with hit (tuser) and read_value
// (tdata: the stored value on a get hit, otherwise zero). A hit, get or set,
// moves the entry to the front; a set miss inserts at the front and, once the
// store holds capacity entries, drops the least recent one. capacity (cfg_we /
// cfg_wdata) counts entries in use, 0 acting as 1 and values above ENTRIES
// acting as ENTRIES; lowering it drops the excess entries at once. Write it only
// while the cache is idle. The key is compared in all cells as the transfer is
// accepted; the update state then runs the match chain and shifts the cells
// that move one place toward the back in parallel, and stalls only while the
// output register is full and not being drained. A new item is taken while the
// previous result still waits in the output register.
module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DFLT
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: capacity
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wdata,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,  // [15:0] key, [47:16] write_value
  input  logic                          s_axis_tuser,  // [0] mode
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // [31:0] read_value
  output logic                          m_axis_tuser   // [0] hit
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic                          state;
  logic                          state_next;
  logic [lkvc_pkg::CAP_W-1:0]    capacity;
  logic [lkvc_pkg::KEY_W-1:0]    req_key;
  logic [lkvc_pkg::VAL_W-1:0]    req_value;
  logic                          req_set;
  logic                          out_valid;
  logic                          out_hit;
  logic [lkvc_pkg::VAL_W-1:0]    out_value;

  logic                          in_fire;
  logic                          upd_fire;
  lkvc_pkg::cell_ctl_t           ctl;
  lkvc_pkg::entry_t              front;
  lkvc_pkg::entry_t              ent       [ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0]    mval      [ENTRIES];
  logic [ENTRIES:0]              seen;
  logic [ENTRIES-1:0]            match_vec;
  logic [ENTRIES-1:0]            valid_vec;
  logic [ENTRIES-1:0]            below_cap;
  logic [ENTRIES-1:0]            below_new_cap;
  logic                          hit_any;
  logic [lkvc_pkg::VAL_W-1:0]    hit_value;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // update only when the result register is free or being drained
  assign upd_fire      = (state == S_UPD) && (!out_valid || m_axis_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_UPD;
      S_UPD:  if (upd_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= lkvc_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (upd_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_key   <= s_axis_tdata[15:0];
      req_value <= s_axis_tdata[47:16];
      req_set   <= (s_axis_tuser == lkvc_pkg::MODE_SET);
    end
    if (upd_fire) begin
      out_hit   <= hit_any;
      out_value <= req_set ? '0 : hit_value;
    end
  end

  // matches are unique, so the hit value is a plain OR over the cells
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | mval[i];
    end
  end

  assign hit_any     = |match_vec;
  assign front.valid = 1'b1;
  assign front.key   = req_key;
  assign front.value = req_set ? req_value : hit_value;

  assign ctl.capture = in_fire;
  assign ctl.update  = upd_fire;
  assign ctl.hit_any = hit_any;
  assign ctl.is_set  = req_set;
  assign ctl.clip    = cfg_we;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    // position i lies inside the capacity when i < max(capacity, 1)
    if (i == 0) begin : g_first
      assign below_cap[i]     = 1'b1;
      assign below_new_cap[i] = 1'b1;
    end else if (i < (1 << lkvc_pkg::CAP_W)) begin : g_mid
      assign below_cap[i]     = capacity  > lkvc_pkg::CAP_W'(i);
      assign below_new_cap[i] = cfg_wdata > lkvc_pkg::CAP_W'(i);
    end else begin : g_far
      assign below_cap[i]     = 1'b0;
      assign below_new_cap[i] = 1'b0;
    end

    lkvc_pkg::entry_t prev;
    if (i == 0) begin : g_head
      assign prev = front;
    end else begin : g_link
      assign prev = ent[i-1];
    end

    lkvc_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .cmp_key       (s_axis_tdata[15:0]),
      .below_cap     (below_cap[i]),
      .below_new_cap (below_new_cap[i]),
      .prev          (prev),
      .seen_in       (seen[i]),
      .cur           (ent[i]),
      .match         (match_vec[i]),
      .seen_out      (seen[i+1]),
      .match_value   (mval[i])
    );

    assign valid_vec[i] = ent[i].valid;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = out_hit;

  // a key lives in at most one cell
  assert property (@(posedge clk) disable iff (rst) $onehot0(match_vec))
    else $error("key matched in more than one cell");

  // valid cells form a contiguous run from the front
  assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + ENTRIES'(1)) & valid_vec) == '0)
    else $error("valid cells not contiguous");

  // occupancy never exceeds the effective capacity
  assert property (@(posedge clk) disable iff (rst)
    ($countones(valid_vec) <= int'(capacity)) || ($countones(valid_vec) <= 1))
    else $error("occupancy above capacity");

  // a set always leaves a valid entry at the front
  assert property (@(posedge clk) disable iff (rst)
    (upd_fire && req_set) |=> valid_vec[0])
    else $error("front cell empty after set");

  // the update state is held until the update fires
  assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && !upd_fire) |=> (state == S_UPD))
    else $error("update cycle lost");

endmodule
